[hdl/ldbp_pkg.sv]
package ldbp_pkg;

    // Width of one weight or distance field on the ports
    localparam int FIELD_W = 32;

    // Slave tdata: weight_from_first, weight_from_second,
    // beer_weight_from_first, beer_weight_from_second
    localparam int S_TDATA_W = 4 * FIELD_W;
    localparam int S_TUSER_W = 1;

    // Master tdata: path_dist, beer_dist, pred_is_first, beer_pred_is_first,
    // beer_on_edge, zero pad to a whole byte
    localparam int M_PAYLOAD_W = 2 * FIELD_W + 3;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 1;

    // Beer candidate codes: {beer_on_edge, beer_pred_is_first}
    localparam logic [1:0] BEER_SECOND_EARLY = 2'b00;
    localparam logic [1:0] BEER_FIRST_EARLY  = 2'b01;
    localparam logic [1:0] BEER_SECOND_EDGE  = 2'b10;
    localparam logic [1:0] BEER_FIRST_EDGE   = 2'b11;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic   path_start;
        t_field w_first;
        t_field w_second;
        t_field bw_first;
        t_field bw_second;
    } t_in_item;

    typedef struct packed {
        t_field     path_dist;
        t_field     beer_dist;
        logic       pred_is_first;
        logic [1:0] beer_code;
        logic       column_slot;
    } t_out_item;

endpackage

[hdl/ladder_dag_beer_path_dp.sv]
// Ladder DAG shortest path / shortest beer path, one vertex per item.
//
// Slave channel (s_axis): one item per vertex after the source, columns of
// two vertices in order. tuser carries path_start, set on the first vertex
// after the source; tdata carries the plain and beer edge weights from the
// previous column's two vertices. All ones means no edge.
// Master channel (m_axis): one item per input item, same order. tdata holds
// the plain and beer distances (all ones = unreachable), the plain and beer
// predecessors and whether the beer stop lies on the incoming edge; tuser
// holds the slot of the vertex in its column.
//
// Each item passes the input register, loaded at the accept, then the result
// register, which loads when it is empty or being taken. Throughput: one item
// per cycle while m_axis_tready does not hold the result register back.
// The column state is updated at the same edge the result register loads, so
// the next vertex in the input register already sees it.
// Reset: both columns act as if path_start had just been seen (distance 0,
// beer distance infinite, slot 0); both pipeline registers empty.
// Stall: when m_axis_tready is low the result register holds, the input
// register holds its item and s_axis_tready drops only once both are full.
module ladder_dag_beer_path_dp #(
    parameter int DIST_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] weight_from_first, [63:32] weight_from_second,
    // [95:64] beer_weight_from_first, [127:96] beer_weight_from_second
    input  logic [ldbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] path_start
    input  logic [ldbp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] path_dist, [63:32] beer_dist, [64] pred_is_first,
    // [65] beer_pred_is_first, [66] beer_on_edge, [71:67] zero
    output logic [ldbp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] column_slot
    output logic [ldbp_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import ldbp_pkg::*;

    localparam logic [DIST_WIDTH-1:0] DIST_INF = '1;

    typedef logic [DIST_WIDTH-1:0] t_dist;

    // Saturating add; infinity absorbs
    function automatic t_dist sat_add(input t_dist a, input t_dist b);
        logic [DIST_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == DIST_INF || b == DIST_INF || s[DIST_WIDTH]) begin
            return DIST_INF;
        end
        return s[DIST_WIDTH-1:0];
    endfunction

    // Port field to internal width: drop upper bits or zero-extend
    function automatic t_dist to_dist(input t_field f);
        logic [DIST_WIDTH+FIELD_W-1:0] x;
        x = {{DIST_WIDTH{1'b0}}, f};
        return x[DIST_WIDTH-1:0];
    endfunction

    function automatic t_field to_field(input t_dist d);
        logic [DIST_WIDTH+FIELD_W-1:0] x;
        x = {{FIELD_W{1'b0}}, d};
        return x[FIELD_W-1:0];
    endfunction

    // ---------------- pipeline control ----------------
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      adv;         // input stage moves into the result register

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // ---------------- column state ----------------
    t_dist r_prev_dist0, r_prev_dist1;
    t_dist r_prev_beer0, r_prev_beer1;
    t_dist r_held_dist,  r_held_beer;
    logic  r_slot;

    // path_start overrides the stored column with the source
    t_dist p_d0, p_d1, p_b0, p_b1;
    logic  eff_slot;

    assign p_d0     = r_in.path_start ? '0       : r_prev_dist0;
    assign p_d1     = r_in.path_start ? '0       : r_prev_dist1;
    assign p_b0     = r_in.path_start ? DIST_INF : r_prev_beer0;
    assign p_b1     = r_in.path_start ? DIST_INF : r_prev_beer1;
    assign eff_slot = r_in.path_start ? 1'b0     : r_slot;

    // ---------------- relaxation ----------------
    t_dist c1, c2, plain_dist;
    logic  pred_first;
    t_dist ba, bb, bc, bd;
    t_dist m_ab, m_cd, bdist;
    logic  sel_b, sel_d, sel_cd;
    logic [1:0] beer_code;

    always_comb begin
        c1         = sat_add(p_d0, to_dist(r_in.w_first));
        c2         = sat_add(p_d1, to_dist(r_in.w_second));
        pred_first = (c1 < c2);
        plain_dist = pred_first ? c1 : c2;

        // Candidates in tie order: earliest wins on equal distance
        ba = sat_add(p_b1, to_dist(r_in.w_second));
        bb = sat_add(p_b0, to_dist(r_in.w_first));
        bc = sat_add(p_d1, to_dist(r_in.bw_second));
        bd = sat_add(p_d0, to_dist(r_in.bw_first));

        sel_b  = (bb < ba);
        m_ab   = sel_b ? bb : ba;
        sel_d  = (bd < bc);
        m_cd   = sel_d ? bd : bc;
        sel_cd = (m_cd < m_ab);
        bdist  = sel_cd ? m_cd : m_ab;

        if (sel_cd) begin
            beer_code = sel_d ? BEER_FIRST_EDGE : BEER_SECOND_EDGE;
        end else begin
            beer_code = sel_b ? BEER_FIRST_EARLY : BEER_SECOND_EARLY;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_dist0 <= '0;
            r_prev_dist1 <= '0;
            r_prev_beer0 <= DIST_INF;
            r_prev_beer1 <= DIST_INF;
            r_held_dist  <= '0;
            r_held_beer  <= DIST_INF;
            r_slot       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                if (!eff_slot) begin
                    // first vertex of the column: park it, keep old column (path_start resets it to the source)
                    r_held_dist <= plain_dist;
                    r_held_beer <= bdist;
                    r_slot      <= 1'b1;
                    if (r_in.path_start) begin
                        r_prev_dist0 <= '0;
                        r_prev_dist1 <= '0;
                        r_prev_beer0 <= DIST_INF;
                        r_prev_beer1 <= DIST_INF;
                    end
                end else begin
                    r_prev_dist0 <= r_held_dist;
                    r_prev_dist1 <= plain_dist;
                    r_prev_beer0 <= r_held_beer;
                    r_prev_beer1 <= bdist;
                    r_slot       <= 1'b0;
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.path_start <= s_axis_tuser[0];
            r_in.w_first    <= s_axis_tdata[FIELD_W-1:0];
            r_in.w_second   <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
            r_in.bw_first   <= s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
            r_in.bw_second  <= s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
        end
        if (adv) begin
            r_out.path_dist     <= to_field(plain_dist);
            r_out.beer_dist     <= to_field(bdist);
            r_out.pred_is_first <= pred_first;
            r_out.beer_code     <= beer_code;
            r_out.column_slot   <= eff_slot;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - M_PAYLOAD_W){1'b0}},
                            r_out.beer_code,
                            r_out.pred_is_first,
                            r_out.beer_dist,
                            r_out.path_dist};
    assign m_axis_tuser  = r_out.column_slot;

    // ---------------- assertions ----------------
    // A first-of-column vertex leaves the slot pointing at the second one
    a_slot_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !eff_slot |=> r_slot)
        else $error("slot did not advance after first vertex");

    // Result slot matches the slot used to compute it
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tuser[0] == $past(eff_slot))
        else $error("column_slot mismatch");

    // Unreachable beer result reports the default predecessor and no edge
    a_beer_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.beer_dist == to_field(DIST_INF)
            && DIST_WIDTH <= FIELD_W
        |-> r_out.beer_code == BEER_SECOND_EARLY)
        else $error("unreachable beer vertex with nonzero predecessor code");

    // Input stage never drops an item it could not hand on
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("input item lost under stall");

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldbp_pkg::*;

    // Generous ceiling: ~1850 items, each at worst with a sender gap plus a
    // receiver stall, plus the long hold and the drain pauses.
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_ITEMS     = 1850;
    localparam int QUIET_TAIL  = 250;   // last items run with no idling
    localparam int LONG_HOLD   = 60;    // cycles of the long receiver hold
    localparam int HOLD_AT     = 400;   // results seen before the long hold

    // Offsets of the result fields in m_axis_tdata
    localparam int PRED_BIT    = 2 * FIELD_W;
    localparam int BPRED_BIT   = 2 * FIELD_W + 1;
    localparam int ONEDGE_BIT  = 2 * FIELD_W + 2;

    localparam t_field NO_EDGE = '1;

    typedef struct {
        t_in_item v;
        bit       drain;   // sender waits for every result before offering it
    } t_pending;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    ladder_dag_beer_path_dp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Column state of the predictor; starts as if a path had just begun
    t_field col_dist [2] = '{'0, '0};
    t_field col_beer [2] = '{'1, '1};
    t_field held_dist    = '0;
    t_field held_beer    = '1;
    logic   slot_q       = 1'b0;

    t_pending  vertex_q[$];      // items still to be offered
    t_out_item vertex_exp_q[$];  // predicted results, oldest first
    t_in_item  cur_item;         // item currently on s_axis
    t_pending  next_pend;        // item just taken from the pending queue
    t_out_item want_vertex;

    // Accept and result counters read across processes use nonblocking writes
    int accepted_cnt = 0;
    int results_seen = 0;
    int quiet_from   = N_ITEMS;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    bit long_done    = 1'b0;
    int outstanding;

    // Idling is off in every third stretch of 150 items and in the tail
    logic idle_ok;
    assign idle_ok = (accepted_cnt < quiet_from) && ((accepted_cnt / 150) % 3 != 1);

    // Saturating add: no edge or overflow gives all ones
    function automatic t_field sat_sum(t_field a, t_field b);
        logic [FIELD_W:0] s;
        if (a == NO_EDGE || b == NO_EDGE) return NO_EDGE;
        s = {1'b0, a} + {1'b0, b};
        return s[FIELD_W] ? NO_EDGE : s[FIELD_W-1:0];
    endfunction

    // Relax one vertex against the previous column and advance the column state
    function automatic t_out_item relax_vertex(t_in_item it);
        t_field    c1, c2, ba, bb, bc, bd, best;
        t_out_item r;
        if (it.path_start) begin
            col_dist[0] = '0;
            col_dist[1] = '0;
            col_beer[0] = NO_EDGE;
            col_beer[1] = NO_EDGE;
            slot_q      = 1'b0;
        end
        // plain: second vertex wins ties
        c1 = sat_sum(col_dist[0], it.w_first);
        c2 = sat_sum(col_dist[1], it.w_second);
        r.pred_is_first = (c1 < c2);
        r.path_dist     = (c1 < c2) ? c1 : c2;
        // beer: either already had it (plain edge) or takes it on the beer edge
        ba = sat_sum(col_beer[1], it.w_second);
        bb = sat_sum(col_beer[0], it.w_first);
        bc = sat_sum(col_dist[1], it.bw_second);
        bd = sat_sum(col_dist[0], it.bw_first);
        best = ba;
        if (bb < best) best = bb;
        if (bc < best) best = bc;
        if (bd < best) best = bd;
        if (best == ba)      r.beer_code = BEER_SECOND_EARLY;
        else if (best == bb) r.beer_code = BEER_FIRST_EARLY;
        else if (best == bc) r.beer_code = BEER_SECOND_EDGE;
        else                 r.beer_code = BEER_FIRST_EDGE;
        r.beer_dist   = best;
        r.column_slot = slot_q;
        if (!slot_q) begin
            held_dist = r.path_dist;
            held_beer = r.beer_dist;
            slot_q    = 1'b1;
        end else begin
            col_dist[0] = held_dist;
            col_dist[1] = r.path_dist;
            col_beer[0] = held_beer;
            col_beer[1] = r.beer_dist;
            slot_q      = 1'b0;
        end
        return r;
    endfunction

    function automatic void queue_vertex(bit start, t_field w1, t_field w2,
                                         t_field bw1, t_field bw2, bit drain);
        t_pending p;
        p.v.path_start = start;
        p.v.w_first    = w1;
        p.v.w_second   = w2;
        p.v.bw_first   = bw1;
        p.v.bw_second  = bw2;
        p.drain        = drain;
        vertex_q.insert(vertex_q.size(), p);
    endfunction

    // Mostly short edges so paths stay finite; some missing, huge and near-max
    function automatic t_field rand_weight();
        case ($urandom_range(0, 19))
            0, 1:    return NO_EDGE;
            2:       return $urandom;
            3:       return NO_EDGE - $urandom_range(1, 1000);
            4:       return $urandom_range(0, 1);
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_cnt++;
        $display("[%0t] %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // Sender: pops pending items, idles in short bursts, holds for drain points
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            outstanding = accepted_cnt - results_seen;
            if (s_axis_tvalid && s_axis_tready) begin
                vertex_exp_q.insert(vertex_exp_q.size(), relax_vertex(cur_item));
                accepted_cnt <= accepted_cnt + 1;
                outstanding++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (vertex_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (vertex_q[0].drain && outstanding != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 5) == 0) begin
                    // idle burst: this cycle plus gap_left more
                    gap_left = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_pend = vertex_q.pop_front();
                    cur_item  = next_pend.v;
                    s_axis_tdata  <= {cur_item.bw_second, cur_item.bw_first,
                                      cur_item.w_second, cur_item.w_first};
                    s_axis_tuser  <= cur_item.path_start;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!long_done && results_seen >= HOLD_AT) begin
            long_done  = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (vertex_exp_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata[63:0], 64'd0);
            end else begin
                want_vertex = vertex_exp_q.pop_front();
                if (m_axis_tdata[FIELD_W-1:0] !== want_vertex.path_dist)
                    report_mismatch("path_dist", 64'(m_axis_tdata[FIELD_W-1:0]),
                                    64'(want_vertex.path_dist));
                if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want_vertex.beer_dist)
                    report_mismatch("beer_dist", 64'(m_axis_tdata[2*FIELD_W-1:FIELD_W]),
                                    64'(want_vertex.beer_dist));
                if (m_axis_tdata[PRED_BIT] !== want_vertex.pred_is_first)
                    report_mismatch("pred_is_first", 64'(m_axis_tdata[PRED_BIT]),
                                    64'(want_vertex.pred_is_first));
                if (m_axis_tdata[BPRED_BIT] !== want_vertex.beer_code[0])
                    report_mismatch("beer_pred_is_first", 64'(m_axis_tdata[BPRED_BIT]),
                                    64'(want_vertex.beer_code[0]));
                if (m_axis_tdata[ONEDGE_BIT] !== want_vertex.beer_code[1])
                    report_mismatch("beer_on_edge", 64'(m_axis_tdata[ONEDGE_BIT]),
                                    64'(want_vertex.beer_code[1]));
                if (m_axis_tdata[M_TDATA_W-1:ONEDGE_BIT+1] !== '0)
                    report_mismatch("tdata pad",
                                    64'(m_axis_tdata[M_TDATA_W-1:ONEDGE_BIT+1]), 64'd0);
                if (m_axis_tuser[0] !== want_vertex.column_slot)
                    report_mismatch("column_slot", 64'(m_axis_tuser[0]),
                                    64'(want_vertex.column_slot));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ladder_dag_beer_path_dp: mismatch");
            $finish;
        end
    end

    initial begin
        int cols;
        int n;
        int j;

        // Directed: reset acts as a path start, then unreachable vertices,
        // plain and beer ties, each beer candidate winning, saturation,
        // a restart mid-column and alternating bit patterns.
        queue_vertex(0, 0, 0, 0, 0, 0);
        queue_vertex(0, NO_EDGE, NO_EDGE, NO_EDGE, NO_EDGE, 0);
        queue_vertex(1, 7, 7, 7, 7, 0);
        queue_vertex(0, 3, 9, 2, NO_EDGE, 0);
        queue_vertex(0, 1, 1, NO_EDGE, NO_EDGE, 0);
        queue_vertex(0, 1, NO_EDGE, NO_EDGE, NO_EDGE, 0);
        queue_vertex(0, NO_EDGE, NO_EDGE, NO_EDGE, NO_EDGE, 0);
        queue_vertex(0, NO_EDGE, NO_EDGE, NO_EDGE, NO_EDGE, 0);
        queue_vertex(0, 5, 5, 5, 5, 0);
        queue_vertex(0, 5, 5, 5, 5, 0);
        queue_vertex(1, NO_EDGE - 1, 1, NO_EDGE - 1, 0, 0);
        queue_vertex(0, NO_EDGE - 1, NO_EDGE - 1, 32'h8000_0000, 32'h7fff_ffff, 0);
        queue_vertex(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        queue_vertex(0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        queue_vertex(1, 0, 0, 0, 0, 0);
        queue_vertex(1, 0, 0, 0, 0, 0);
        queue_vertex(0, NO_EDGE, 0, NO_EDGE, 0, 0);
        queue_vertex(0, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 0);
        queue_vertex(0, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 0);
        queue_vertex(0, 4, 4, 3, 3, 0);

        // Random: mostly whole paths, a few cut after a first vertex, and
        // some lone items with random start bits and full-range weights.
        while (vertex_q.size() < N_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                queue_vertex(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                             $urandom, 0);
            end else begin
                cols = $urandom_range(1, 24);
                n    = ($urandom_range(0, 7) == 0) ? 2 * cols - 1 : 2 * cols;
                for (j = 0; j < n; j++)
                    queue_vertex(j == 0, rand_weight(), rand_weight(), rand_weight(),
                                 rand_weight(), 0);
            end
        end
        // Sender pauses for a full drain at a few points
        vertex_q[20].drain   = 1'b1;
        vertex_q[700].drain  = 1'b1;
        vertex_q[1300].drain = 1'b1;
        quiet_from = vertex_q.size() - QUIET_TAIL;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the stimulus to be taken and every result to come back
        do begin
            @(posedge i_clk);
            #1;
        end while (vertex_q.size() != 0 || s_axis_tvalid || accepted_cnt != results_seen);

        // Two-stage pipeline: wait to catch any stray result
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && vertex_exp_q.size() == 0) begin
            $display("ladder_dag_beer_path_dp: match");
        end else begin
            $display("ladder_dag_beer_path_dp: mismatch");
        end
        $finish;
    end

endmodule

[ladder_dag_beer_path_dp.f]
hdl/ldbp_pkg.sv
hdl/ladder_dag_beer_path_dp.sv
verif/tb_top.sv
